[sv/mpfc_pkg.sv]
// Shared types and constants of the multichannel pulse frequency counter.
package mpfc_pkg;

  localparam int unsigned CHANNELS = 8;
  localparam int unsigned CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int unsigned RATE_W      = 20;
  localparam logic [RATE_W-1:0] RATE_SCALE = RATE_W'(1000000);
  localparam int unsigned PROD_W      = 32 + RATE_W;
  localparam int unsigned DIV_CNT_W   = $clog2(PROD_W);

  localparam logic [31:0] STATE_INTERVAL_RESET = 32'd200000;

  localparam logic [1:0] CMD_EDGE     = 2'd0;
  localparam logic [1:0] CMD_POLL     = 2'd1;
  localparam logic [1:0] CMD_PERIODIC = 2'd2;

  localparam logic KIND_STATE    = 1'b0;
  localparam logic KIND_PERIODIC = 1'b1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  channel;
    logic [31:0] time_now_us;
    logic        pin_level;
  } item_t;

  typedef struct packed {
    logic [2:0]  report_channel;
    logic        report_kind;
    logic        active;
    logic        rate_valid;
    logic        zero_interval;
    logic [31:0] edge_rate_half_hz;
    logic [30:0] pulse_count;
  } report_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_SAT,
    ST_SEND
  } state_t;

endpackage

[sv/multichannel_pulse_frequency_counter_core.sv]
// Per-channel edge counter with state reports and edge rate measurement.
//
// Each request names a channel and a command: an edge bumps the channel's edge count and
// sets its change flag, a state poll reports the active-low pin level at most once per
// min_state_interval_us and only after an edge, and a periodic request reports the edge
// rate in half-hertz units since the previous periodic report plus the pulse count. The
// block takes one request at a time. An edge, a poll that gives no report and an unused
// command pass through accept and evaluate. A poll that reports, and a periodic request
// whose elapsed time is zero or wrapped, pass through accept, evaluate and hand-off to the
// output register. A periodic report with a nonzero elapsed time also passes through
// multiply, divide and saturate steps: the edge delta is multiplied by one million, then a
// shared restoring divider produces one quotient bit per cycle over the 52-bit product,
// and the result is saturated to 32 bits. The hand-off waits while the output register
// still holds a stalled report. Finished reports wait in the output register, so a new
// request is taken while a report is still stalled.
module multichannel_pulse_frequency_counter_core
  import mpfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        report_valid,
  input  logic        report_stall,
  output report_t     report,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  state_t state, state_next;

  logic [31:0] edge_count           [CHANNELS];
  logic        change_pending       [CHANNELS];
  logic [31:0] last_state_time      [CHANNELS];
  logic [31:0] last_periodic_time   [CHANNELS];
  logic [31:0] count_at_last_report [CHANNELS];
  logic [31:0] min_state_interval_us;

  item_t                cur;
  report_t              res;
  logic [31:0]          diff;
  logic [31:0]          delta;
  logic [PROD_W-1:0]    num;
  logic [31:0]          rem;
  logic [DIV_CNT_W-1:0] cnt;

  logic [CH_IDX_W-1:0] idx;
  logic                chan_ok;
  logic [31:0]         stamp;
  logic [32:0]         sub_w;
  logic                behind;
  logic [31:0]         elapsed;
  logic                too_early;
  logic                poll_ok;
  logic                periodic_ok;
  logic                accept;
  logic                slot_free;
  logic [32:0]         trial;
  logic [32:0]         rem_shift;

  assign accept    = item_valid && !item_stall;
  assign slot_free = !report_valid || !report_stall;

  // Evaluation compares the addressed stamp once; the subtract borrow flags a time wrap.
  assign idx       = CH_IDX_W'(cur.channel);
  assign chan_ok   = 32'(cur.channel) < CHANNELS;
  assign stamp     = (cur.cmd == CMD_POLL) ? last_state_time[idx] : last_periodic_time[idx];
  assign sub_w     = {1'b0, cur.time_now_us} - {1'b0, stamp};
  assign behind    = sub_w[32];
  assign elapsed   = sub_w[31:0];
  assign too_early = elapsed < min_state_interval_us;
  assign poll_ok   = change_pending[idx] && !behind && !too_early;
  assign periodic_ok = !behind && (elapsed != 32'd0);

  // One restoring divide step: bring down the next dividend bit and try the subtract.
  assign rem_shift = {rem, num[PROD_W-1]};
  assign trial     = rem_shift - {1'b0, delta};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_next = ST_IDLE;
        if (chan_ok) begin
          priority case (cur.cmd)
            CMD_POLL: begin
              if (poll_ok) begin
                state_next = ST_SEND;
              end
            end
            CMD_PERIODIC: begin
              state_next = periodic_ok ? ST_MUL : ST_SEND;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_MUL: state_next = ST_DIV;
      ST_DIV: begin
        if (cnt == '0) begin
          state_next = ST_SAT;
        end
      end
      ST_SAT: state_next = ST_SEND;
      ST_SEND: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Channel state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        edge_count[i]           <= '0;
        change_pending[i]       <= 1'b0;
        last_state_time[i]      <= '0;
        last_periodic_time[i]   <= '0;
        count_at_last_report[i] <= '0;
      end
      min_state_interval_us <= STATE_INTERVAL_RESET;
    end else begin
      if (cfg_wr_en) begin
        min_state_interval_us <= cfg_wr_data;
      end
      if (state == ST_EVAL && chan_ok) begin
        priority case (cur.cmd)
          CMD_EDGE: begin
            change_pending[idx] <= 1'b1;
            edge_count[idx]     <= edge_count[idx] + 32'd1;
          end
          CMD_POLL: begin
            if (change_pending[idx] && (behind || !too_early)) begin
              last_state_time[idx] <= cur.time_now_us;
            end
            if (poll_ok) begin
              change_pending[idx] <= 1'b0;
            end
          end
          CMD_PERIODIC: begin
            if (behind || periodic_ok) begin
              last_periodic_time[idx] <= cur.time_now_us;
            end
            if (periodic_ok) begin
              count_at_last_report[idx] <= edge_count[idx];
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Request capture, report build and the shared multiply/divide datapath.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= item;
    end
    unique case (state)
      ST_EVAL: begin
        res.report_channel    <= cur.channel;
        res.report_kind       <= (cur.cmd == CMD_POLL) ? KIND_STATE : KIND_PERIODIC;
        res.active            <= ~cur.pin_level;
        res.rate_valid        <= (cur.cmd == CMD_PERIODIC) && periodic_ok;
        res.zero_interval     <= (cur.cmd == CMD_PERIODIC) && !behind && (elapsed == 32'd0);
        res.edge_rate_half_hz <= '0;
        res.pulse_count       <= ((cur.cmd == CMD_PERIODIC) && periodic_ok) ?
                                 edge_count[idx][31:1] : '0;
        diff  <= edge_count[idx] - count_at_last_report[idx];
        delta <= elapsed;
      end
      ST_MUL: begin
        num <= PROD_W'(diff) * PROD_W'(RATE_SCALE);
        rem <= '0;
        cnt <= DIV_CNT_W'(PROD_W - 1);
      end
      ST_DIV: begin
        // The dividend shifts out at the top while quotient bits fill in at the bottom.
        if (!trial[32]) begin
          rem <= trial[31:0];
          num <= {num[PROD_W-2:0], 1'b1};
        end else begin
          rem <= rem_shift[31:0];
          num <= {num[PROD_W-2:0], 1'b0};
        end
        cnt <= cnt - DIV_CNT_W'(1);
      end
      ST_SAT: begin
        res.edge_rate_half_hz <= (|num[PROD_W-1:32]) ? '1 : num[31:0];
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
    end else if (state == ST_SEND && slot_free) begin
      report_valid <= 1'b1;
    end else if (!report_stall) begin
      report_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SEND && slot_free) begin
      report <= res;
    end
  end

endmodule

[test/tb_multichannel_pulse_frequency_counter_core.sv]
// Self-checking testbench of the multichannel pulse frequency counter core.
module tb_multichannel_pulse_frequency_counter_core;
  import mpfc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  CMD_UNUSED    = 2'd3;
  localparam logic [63:0] RATE_UNIT     = 64'd1000000;
  localparam logic [31:0] TIME_MAX      = 32'hFFFF_FFFF;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned MAX_SHOWN     = 10;
  localparam int unsigned BURST_EDGES   = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  item_t       item = '0;
  logic        report_valid;
  logic        report_stall = 1'b0;
  report_t     report;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;

  multichannel_pulse_frequency_counter_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .report_valid (report_valid),
    .report_stall (report_stall),
    .report       (report),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always #4 clk = ~clk;

  // Predicted channel state and the interval register copy.
  logic [31:0] edge_total        [CHANNELS] = '{default: '0};
  logic        change_seen       [CHANNELS] = '{default: 1'b0};
  logic [31:0] state_stamp       [CHANNELS] = '{default: '0};
  logic [31:0] periodic_stamp    [CHANNELS] = '{default: '0};
  logic [31:0] edges_at_periodic [CHANNELS] = '{default: '0};
  logic [31:0] state_gap_min = STATE_INTERVAL_RESET;

  // Per-channel time cursor used to build request sequences.
  logic [31:0] sequence_clock [CHANNELS] = '{default: '0};

  item_t       pending_items[$];
  report_t     expected_reports[$];
  int unsigned mismatches = 0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;

  function automatic int unsigned draw_wait(input bit burst);
    return burst ? 0 : $urandom_range(0, 19);
  endfunction

  task automatic predict_report(input item_t req);
    report_t     rep;
    int unsigned ch;
    logic [31:0] elapsed;
    logic [31:0] new_edges;
    logic [63:0] rate_wide;
    ch = req.channel;
    rep = '0;
    rep.report_channel = req.channel;
    rep.active = ~req.pin_level;
    case (req.cmd)
      CMD_EDGE: begin
        change_seen[ch] = 1'b1;
        edge_total[ch] = edge_total[ch] + 32'd1;
      end
      CMD_POLL: begin
        if (change_seen[ch]) begin
          if (req.time_now_us < state_stamp[ch]) begin
            state_stamp[ch] = req.time_now_us;
          end else if (req.time_now_us - state_stamp[ch] >= state_gap_min) begin
            state_stamp[ch] = req.time_now_us;
            change_seen[ch] = 1'b0;
            rep.report_kind = KIND_STATE;
            expected_reports.push_back(rep);
          end
        end
      end
      CMD_PERIODIC: begin
        rep.report_kind = KIND_PERIODIC;
        if (req.time_now_us < periodic_stamp[ch]) begin
          periodic_stamp[ch] = req.time_now_us;
        end else if (req.time_now_us == periodic_stamp[ch]) begin
          rep.zero_interval = 1'b1;
        end else begin
          elapsed = req.time_now_us - periodic_stamp[ch];
          new_edges = edge_total[ch] - edges_at_periodic[ch];
          rate_wide = ({32'd0, new_edges} * RATE_UNIT) / {32'd0, elapsed};
          rep.rate_valid = 1'b1;
          rep.edge_rate_half_hz = (rate_wide > {32'd0, TIME_MAX}) ? TIME_MAX : rate_wide[31:0];
          rep.pulse_count = edge_total[ch][31:1];
          edges_at_periodic[ch] = edge_total[ch];
          periodic_stamp[ch] = req.time_now_us;
        end
        expected_reports.push_back(rep);
      end
      default: ;
    endcase
  endtask

  task automatic check_report(input report_t want, input report_t got);
    if (want.report_channel !== got.report_channel || want.report_kind !== got.report_kind ||
        want.active !== got.active || want.rate_valid !== got.rate_valid ||
        want.zero_interval !== got.zero_interval ||
        want.edge_rate_half_hz !== got.edge_rate_half_hz ||
        want.pulse_count !== got.pulse_count) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN) begin
        $display("report mismatch at %0t: expected ch %0d kind %0d act %0d valid %0d",
                 $realtime, want.report_channel, want.report_kind, want.active,
                 want.rate_valid);
        $display("  expected zero %0d rate %0d count %0d",
                 want.zero_interval, want.edge_rate_half_hz, want.pulse_count);
        $display("  actual ch %0d kind %0d act %0d valid %0d zero %0d rate %0d count %0d",
                 got.report_channel, got.report_kind, got.active, got.rate_valid,
                 got.zero_interval, got.edge_rate_half_hz, got.pulse_count);
      end
    end
  endtask

  // Request driver: predicts each accepted request, then waits its drawn gap.
  always @(posedge clk) begin : request_driver
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        predict_report(item);
        tx_wait = draw_wait(tx_burst);
        if ($urandom_range(0, 39) == 0) tx_burst = ~tx_burst;
      end
      if (item_valid && item_stall) begin
        // Hold the stalled request as it is.
      end else if (tx_wait > 0) begin
        tx_wait--;
        item_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        item <= pending_items.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : report_monitor
    report_t want;
    if (rst) begin
      report_stall <= 1'b0;
    end else begin
      if (report_valid && !report_stall) begin
        if (expected_reports.size() == 0) begin
          want = '0;
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("unexpected report at %0t: ch %0d kind %0d", $realtime,
                     report.report_channel, report.report_kind);
        end else begin
          want = expected_reports.pop_front();
          check_report(want, report);
        end
        rx_wait = draw_wait(rx_burst);
        if ($urandom_range(0, 39) == 0) rx_burst = ~rx_burst;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      report_stall <= (rx_wait != 0);
    end
  end

  task automatic queue_request(input logic [1:0] cmd, input int unsigned ch,
                               input logic [31:0] stamp, input logic pin);
    item_t req;
    req.cmd = cmd;
    req.channel = 3'(ch);
    req.time_now_us = stamp;
    req.pin_level = pin;
    pending_items.push_back(req);
  endtask

  function automatic logic [31:0] draw_step();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return $urandom;
      2, 3, 4: return $urandom_range(1, 1000);
      default: return $urandom_range(1000, 400000);
    endcase
  endfunction

  // Mostly edge bursts closed by a poll or a periodic request on one channel,
  // with some fully random requests mixed in.
  task automatic queue_traffic(input int unsigned target);
    int unsigned queued;
    int unsigned ch;
    int unsigned pick;
    int unsigned edges;
    item_t       noise;
    queued = 0;
    while (queued < target) begin
      pick = $urandom_range(0, 9);
      ch = $urandom_range(0, CHANNELS - 1);
      if (pick == 0) begin
        noise = item_t'({$urandom, $urandom});
        pending_items.push_back(noise);
        if (noise.cmd != CMD_UNUSED) queued++;
      end else begin
        edges = $urandom_range(0, 5);
        repeat (edges) begin
          sequence_clock[ch] += $urandom_range(0, 50000);
          queue_request(CMD_EDGE, ch, sequence_clock[ch], 1'($urandom));
        end
        sequence_clock[ch] += draw_step();
        queue_request((pick < 6) ? CMD_POLL : CMD_PERIODIC, ch, sequence_clock[ch],
                      1'($urandom));
        queued += edges + 1;
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_items.size() != 0 || item_valid || expected_reports.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Called at a rising edge with the block idle.
  task automatic write_interval(input logic [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    state_gap_min = value;
    @(negedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed cases under the reset interval.
    queue_request(CMD_POLL, 0, 32'd0, 1'b1);          // no edge seen yet
    queue_request(CMD_PERIODIC, 0, 32'd0, 1'b0);      // zero elapsed time
    repeat (3) queue_request(CMD_EDGE, 0, 32'd10, 1'b0);
    queue_request(CMD_POLL, 0, 32'd199999, 1'b0);     // too early
    queue_request(CMD_POLL, 0, 32'd200000, 1'b0);
    queue_request(CMD_PERIODIC, 0, 32'd1000, 1'b1);
    queue_request(CMD_PERIODIC, 0, 32'd500, 1'b0);    // time went backwards
    queue_request(CMD_EDGE, 0, 32'd0, 1'b1);
    queue_request(CMD_POLL, 0, 32'd5, 1'b0);          // poll stamp wraps
    queue_request(CMD_POLL, 0, 32'd200005, 1'b1);
    queue_request(CMD_UNUSED, 7, TIME_MAX, 1'b1);
    queue_request(CMD_EDGE, 5, TIME_MAX, 1'b0);
    queue_request(CMD_PERIODIC, 5, TIME_MAX, 1'b0);
    queue_request(CMD_EDGE, 5, 32'd0, 1'b1);
    queue_request(CMD_PERIODIC, 5, TIME_MAX, 1'b1);
    queue_request(CMD_PERIODIC, 5, 32'd0, 1'b0);
    repeat (2) queue_request(CMD_EDGE, 6, 32'd0, 1'b0);
    queue_request(CMD_PERIODIC, 6, 32'd1, 1'b1);
    wait_idle();

    write_interval(32'd0);
    queue_traffic(250);
    wait_idle();

    write_interval(TIME_MAX);
    // Only an elapsed time of all ones passes the largest interval.
    queue_request(CMD_EDGE, 2, 32'd7, 1'b0);
    queue_request(CMD_POLL, 2, 32'd0, 1'b0);
    queue_request(CMD_POLL, 2, TIME_MAX, 1'b0);
    queue_traffic(200);
    wait_idle();

    write_interval(32'd1000);
    queue_traffic(250);
    // A dense edge burst over one microsecond gives a very high rate.
    queue_request(CMD_PERIODIC, 7, 32'd12345, 1'b1);
    repeat (BURST_EDGES) queue_request(CMD_EDGE, 7, 32'd12345, 1'b0);
    queue_request(CMD_PERIODIC, 7, 32'd12346, 1'b0);
    wait_idle();

    write_interval($urandom_range(1, 300000));
    queue_traffic(250);
    wait_idle();

    write_interval(32'd1);
    queue_traffic(250);
    wait_idle();

    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
